>>> hdl/qebv_pkg.sv
`default_nettype none

package qebv_pkg;

    localparam int VAL_W       = 7;
    localparam int LEVEL_W     = 4;
    localparam int QUERY_W     = 2;
    localparam int GROUP_W     = 3;
    localparam int GROUP_COUNT = 8;

    localparam logic [VAL_W-1:0] VALUE_MAX = 7'd127;
    localparam logic [VAL_W-1:0] VALUE_MIN = 7'd0;

    typedef struct packed {
        logic [LEVEL_W-1:0] a_levels;
        logic [LEVEL_W-1:0] b_levels;
        logic [QUERY_W-1:0] query_index;
    } t_in_word;

    typedef struct packed {
        logic [VAL_W-1:0]   query_value;
        logic [LEVEL_W-1:0] changed_mask;
    } t_out_word;

    // per-tick controls carried from acceptance into the update stage
    typedef struct packed {
        logic [LEVEL_W-1:0] a_levels;
        logic [LEVEL_W-1:0] b_levels;
        logic [LEVEL_W-1:0] changed;
        logic [QUERY_W-1:0] query_index;
    } t_tick_ctl;

endpackage

`default_nettype wire

>>> hdl/qebv_row_ram.sv
`default_nettype none

module qebv_row_ram
    import qebv_pkg::*;
#(
    parameter int DEPTH  = 8,
    parameter int ADDR_W = 3,
    parameter int WIDTH  = 28
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output      logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> hdl/qebv_update.sv
`default_nettype none

module qebv_update
    import qebv_pkg::*;
#(
    parameter int LANES = 4
) (
    input  wire logic [LANES*VAL_W-1:0] i_row,
    input  wire t_tick_ctl              i_ctl,
    output      logic [LANES*VAL_W-1:0] o_row,
    output      logic [VAL_W-1:0]       o_query_value
);

    always_comb begin
        logic [VAL_W-1:0] v;
        o_row = i_row;
        for (int i = 0; i < LANES; i++) begin
            v = i_row[i*VAL_W +: VAL_W];
            if (i_ctl.changed[i]) begin
                // A equal to B counts up, otherwise down; clamp at both ends
                if (i_ctl.a_levels[i] == i_ctl.b_levels[i]) begin
                    if (v != VALUE_MAX) begin
                        v = v + VAL_W'(1);
                    end
                end else begin
                    if (v != VALUE_MIN) begin
                        v = v - VAL_W'(1);
                    end
                end
            end
            o_row[i*VAL_W +: VAL_W] = v;
        end
    end

    // an index with no encoder behind it reports zero
    always_comb begin
        o_query_value = '0;
        for (int i = 0; i < LANES; i++) begin
            if (i_ctl.query_index == QUERY_W'(i)) begin
                o_query_value = o_row[i*VAL_W +: VAL_W];
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/quad_encoder_banked_values_core.sv
// Banked quadrature decoder for four encoders, counting on both edges of phase A.
// Input channel (i_in_valid / o_in_ready, i_in_word): one word per sample tick
// with the A and B levels and the index of the encoder to report.
// Output channel (o_out_valid / i_out_ready, o_out_word): one word per tick with
// the queried value after the update and the mask of encoders that saw an A edge.
// i_cfg_we / i_cfg_wdata select the group of values; write only while idle.
// The result word is registered: the group-row read is launched at the accepting
// edge, and the update lands in the output register once the receiver is free.
// Throughput: one word per cycle while the receiver does not stall; a write to
// the row and the read for the next word in the same cycle are bypassed, so words
// can follow back to back.
// When the receiver stalls, the output register holds, the update stage holds
// and o_in_ready drops once that stage is full; nothing is lost.
// Reset clears the group select, the previous A levels and the row valid bits;
// a row never written reads as START_VALUE in every lane, so no clearing pass.
`default_nettype none

module quad_encoder_banked_values_core
    import qebv_pkg::*;
#(
    parameter int NUM_ENCODERS = 4,
    parameter int NUM_GROUPS   = 8,
    parameter int START_VALUE  = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [GROUP_W-1:0] i_cfg_wdata,
    input  wire logic               i_in_valid,
    output      logic               o_in_ready,
    input  wire t_in_word           i_in_word,
    output      logic               o_out_valid,
    input  wire logic               i_out_ready,
    output      t_out_word          o_out_word
);

    localparam int LANES  = (NUM_ENCODERS < LEVEL_W) ? NUM_ENCODERS : LEVEL_W;
    localparam int ROWS   = (NUM_GROUPS < GROUP_COUNT) ? NUM_GROUPS : GROUP_COUNT;
    localparam int ADDR_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int ROW_W  = LANES * VAL_W;

    localparam logic [GROUP_W-1:0] LAST_GROUP = GROUP_W'(ROWS - 1);
    localparam logic [LEVEL_W-1:0] LANE_MASK  = LEVEL_W'((1 << LANES) - 1);
    localparam logic [VAL_W-1:0]   START_VAL  = VAL_W'(START_VALUE);
    localparam logic [ROW_W-1:0]   START_ROW  = {LANES{START_VAL}};

    logic [GROUP_W-1:0] r_group;
    logic [LEVEL_W-1:0] r_prev_a;
    logic [ROWS-1:0]    r_row_valid;

    logic               r_s1_valid;
    t_tick_ctl          r_s1_ctl;
    logic [ADDR_W-1:0]  r_s1_addr;
    logic               r_src_fwd;
    logic               r_src_valid;
    logic [ROW_W-1:0]   r_fwd_row;

    logic               r_out_valid;
    t_out_word          r_out_word;

    logic [GROUP_W-1:0] act_group;
    logic [ADDR_W-1:0]  rd_addr;
    logic               in_fire;
    logic               out_free;
    logic               s1_go;
    logic [ROW_W-1:0]   mem_rdata;
    logic [ROW_W-1:0]   cur_row;
    logic [ROW_W-1:0]   new_row;
    logic [VAL_W-1:0]   query_value;
    logic               wr_hit;

    assign act_group  = (r_group > LAST_GROUP) ? LAST_GROUP : r_group;
    assign rd_addr    = act_group[ADDR_W-1:0];
    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_go      = r_s1_valid && out_free;
    assign o_in_ready = !r_s1_valid || out_free;
    assign in_fire    = i_in_valid && o_in_ready;
    assign wr_hit     = s1_go && (r_s1_addr == rd_addr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group <= '0;
        end else if (i_cfg_we) begin
            r_group <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_a    <= '0;
            r_s1_valid  <= 1'b0;
            r_row_valid <= '0;
        end else begin
            if (in_fire) begin
                r_prev_a   <= i_in_word.a_levels & LANE_MASK;
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_go) begin
                r_row_valid[r_s1_addr] <= 1'b1;
            end
        end
    end

    // capture the tick and where its row will come from
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_ctl.a_levels    <= i_in_word.a_levels;
            r_s1_ctl.b_levels    <= i_in_word.b_levels;
            r_s1_ctl.changed     <= (i_in_word.a_levels ^ r_prev_a) & LANE_MASK;
            r_s1_ctl.query_index <= i_in_word.query_index;
            r_s1_addr            <= rd_addr;
            r_src_fwd            <= wr_hit;
            r_src_valid          <= r_row_valid[rd_addr];
        end
        if (s1_go) begin
            r_fwd_row <= new_row;
        end
    end

    qebv_row_ram #(
        .DEPTH  (ROWS),
        .ADDR_W (ADDR_W),
        .WIDTH  (ROW_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (s1_go),
        .i_waddr (r_s1_addr),
        .i_wdata (new_row),
        .i_re    (in_fire),
        .i_raddr (rd_addr),
        .o_rdata (mem_rdata)
    );

    // bypass the row written in the read cycle; unwritten rows hold the start value
    always_comb begin
        if (r_src_fwd) begin
            cur_row = r_fwd_row;
        end else if (r_src_valid) begin
            cur_row = mem_rdata;
        end else begin
            cur_row = START_ROW;
        end
    end

    qebv_update #(
        .LANES (LANES)
    ) u_update (
        .i_row         (cur_row),
        .i_ctl         (r_s1_ctl),
        .o_row         (new_row),
        .o_query_value (query_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_out_word.query_value  <= query_value;
            r_out_word.changed_mask <= r_s1_ctl.changed;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import qebv_pkg::*;

    localparam int ENC_COUNT    = 4;
    localparam int START_COUNT  = 64;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int PHASE_WORDS  = 85;
    localparam int PHASE_COUNT  = 12;
    localparam int DRAIN_CYCLES = 10;

    typedef enum int {MOVE_HOLD, MOVE_UP, MOVE_DOWN, MOVE_NOISE} t_move;

    // Predicts the per-tick word from its own copy of the count table.
    class encoder_scoreboard;
        logic [LEVEL_W-1:0] last_a;
        logic [VAL_W-1:0]   counts [ENC_COUNT][GROUP_COUNT];
        logic [GROUP_W-1:0] group;
        t_out_word          expected_q [$];
        int                 errors;

        function new();
            last_a = '0;
            group  = '0;
            errors = 0;
            foreach (counts[e, g]) counts[e][g] = VAL_W'(START_COUNT);
        endfunction

        function void set_group(logic [GROUP_W-1:0] g);
            group = g;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_input(t_in_word w);
            t_out_word          r;
            logic [LEVEL_W-1:0] changed;
            logic               a;
            logic               b;
            changed = '0;
            for (int e = 0; e < ENC_COUNT; e++) begin
                a = w.a_levels[e];
                b = w.b_levels[e];
                if (a != last_a[e]) begin
                    // step toward B agreement; clamp at both ends
                    if (a == b) begin
                        if (counts[e][group] != VALUE_MAX)
                            counts[e][group] = counts[e][group] + 1'b1;
                    end else begin
                        if (counts[e][group] != VALUE_MIN)
                            counts[e][group] = counts[e][group] - 1'b1;
                    end
                    changed[e] = 1'b1;
                    last_a[e]  = a;
                end
            end
            r.query_value  = counts[w.query_index][group];
            r.changed_mask = changed;
            expected_q.push_back(r);
        endfunction

        function void check_result(t_out_word r);
            t_out_word x;
            if (expected_q.size() == 0) begin
                $error("result word with nothing expected: query_value %0d changed_mask %h",
                       r.query_value, r.changed_mask);
                errors++;
                return;
            end
            x = expected_q.pop_front();
            if (r.query_value !== x.query_value) begin
                $error("query_value mismatch: expected %0d, actual %0d",
                       x.query_value, r.query_value);
                errors++;
            end
            if (r.changed_mask !== x.changed_mask) begin
                $error("changed_mask mismatch: expected %h, actual %h",
                       x.changed_mask, r.changed_mask);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [GROUP_W-1:0] i_cfg_wdata;
    logic               i_in_valid;
    logic               o_in_ready;
    t_in_word           i_in_word;
    logic               o_out_valid;
    logic               i_out_ready;
    t_out_word          o_out_word;

    encoder_scoreboard  sb;
    int                 cycle_count = 0;
    int                 tx_idle_pct = 0;
    int                 rx_stall_pct = 0;
    int                 rx_hold_req = 0;
    int                 rx_hold_left = 0;

    // stimulus generator state
    logic [LEVEL_W-1:0] gen_last_a = '0;
    int                 run_left = 0;
    t_move              run_moves [ENC_COUNT];

    quad_encoder_banked_values_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // check the outgoing word before noting the incoming one
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                sb.check_result(o_out_word);
            if (i_in_valid && o_in_ready)
                sb.note_input(i_in_word);
        end
    end

    always @(negedge i_clk) begin
        if (rx_hold_req > 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    function automatic t_in_word tick_word(logic [LEVEL_W-1:0] a, logic [LEVEL_W-1:0] b,
                                           logic [QUERY_W-1:0] q);
        t_in_word w;
        w.a_levels    = a;
        w.b_levels    = b;
        w.query_index = q;
        return w;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_word(t_in_word w);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
        gen_last_a = w.a_levels;
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_group(logic [GROUP_W-1:0] g);
        drain_results();
        repeat (4) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= g;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_group(g);
    endtask

    // Runs of coherent rotation reach the clamps; the rest is noise.
    function automatic t_in_word next_word();
        t_in_word w;
        t_move    m;
        if (run_left == 0) begin
            run_left = ($urandom_range(9) < 3) ? $urandom_range(140, 64) : $urandom_range(16, 1);
            if ($urandom_range(1)) begin
                m = t_move'($urandom_range(3));
                foreach (run_moves[e]) run_moves[e] = m;
            end else begin
                foreach (run_moves[e]) run_moves[e] = t_move'($urandom_range(3));
            end
        end
        run_left--;
        w.a_levels    = LEVEL_W'($urandom);
        w.b_levels    = LEVEL_W'($urandom);
        w.query_index = QUERY_W'($urandom_range(3));
        if ($urandom_range(9) != 0) begin
            for (int e = 0; e < ENC_COUNT; e++) begin
                case (run_moves[e])
                    MOVE_HOLD: begin
                        w.a_levels[e] = gen_last_a[e];
                    end
                    MOVE_UP: begin
                        w.a_levels[e] = ~gen_last_a[e];
                        w.b_levels[e] = ~gen_last_a[e];
                    end
                    MOVE_DOWN: begin
                        w.a_levels[e] = ~gen_last_a[e];
                        w.b_levels[e] = gen_last_a[e];
                    end
                    default: begin
                    end
                endcase
            end
        end
        return w;
    endfunction

    initial begin
        int tx_modes [4] = '{0, 77, 0, 10};
        int rx_modes [4] = '{0, 0, 77, 10};
        int group_plan [PHASE_COUNT] = '{7, 0, 3, 7, 1, 4, 0, 5, 2, 6, 7, 3};

        sb          = new();
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        i_in_valid  = 1'b0;
        i_in_word   = '0;
        i_out_ready = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // edges in both directions on every encoder, holds, B-only changes
        send_word(tick_word(4'h0, 4'h0, 2'd0));
        send_word(tick_word(4'hF, 4'hF, 2'd0));
        send_word(tick_word(4'hF, 4'h0, 2'd1));
        send_word(tick_word(4'h0, 4'hF, 2'd1));
        send_word(tick_word(4'hF, 4'h0, 2'd2));
        send_word(tick_word(4'h0, 4'h0, 2'd3));
        send_word(tick_word(4'h5, 4'h5, 2'd0));
        send_word(tick_word(4'hA, 4'h5, 2'd1));
        send_word(tick_word(4'hA, 4'hA, 2'd2));
        send_word(tick_word(4'h0, 4'hA, 2'd3));
        send_word(tick_word(4'hF, 4'hF, 2'd3));
        send_word(tick_word(4'hF, 4'hF, 2'd2));
        send_word(tick_word(4'h3, 4'hC, 2'd0));
        send_word(tick_word(4'hC, 4'h3, 2'd1));
        send_word(tick_word(4'h0, 4'h0, 2'd2));
        send_word(tick_word(4'h1, 4'h1, 2'd0));
        send_word(tick_word(4'h3, 4'h2, 2'd1));
        send_word(tick_word(4'h7, 4'h4, 2'd2));
        send_word(tick_word(4'hF, 4'h8, 2'd3));

        for (int p = 0; p < PHASE_COUNT; p++) begin
            write_group(GROUP_W'(group_plan[p]));
            tx_idle_pct  = tx_modes[p % 4];
            rx_stall_pct = rx_modes[p % 4];
            for (int i = 0; i < PHASE_WORDS; i++) begin
                // stall the receiver long enough to back up the input
                if (p == 4 && i == 40)
                    rx_hold_req = 60;
                // hold off until every outstanding word is back
                if (p == 8 && i == 40)
                    drain_results();
                send_word(next_word());
            end
        end

        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
